/* design/mpd_pkg.sv */
// ----------------------------------------------------------------------------
// mpd_pkg - shared types and codes of the multi-pin debouncer
// Holds the field widths, action and register codes, the packed input word
// and result layouts, and the per-pin command struct.
// ----------------------------------------------------------------------------
package mpd_pkg;

    localparam int ACT_W    = 2;
    localparam int IDX_W    = 3;
    localparam int PIN_W    = 8;
    localparam int TICKS_W  = 10;
    localparam int CFG_A_W  = 1;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;

    // action codes
    localparam logic [ACT_W-1:0] ACT_TICK = 2'd0;
    localparam logic [ACT_W-1:0] ACT_EDGE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ACK  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_DEBOUNCE_TICKS   = 1'b0;
    localparam logic [CFG_A_W-1:0] REG_ACTIVE_HIGH_MASK = 1'b1;

    localparam logic [TICKS_W-1:0] DEBOUNCE_TICKS_RST   = 10'd10;
    localparam logic [PIN_W-1:0]   ACTIVE_HIGH_MASK_RST = 8'hFF;

    // input word, action in the lowest bits
    typedef struct packed {
        logic [PIN_W-1:0] pin_levels;
        logic [IDX_W-1:0] pin_index;
        logic [ACT_W-1:0] action;
    } item_t;

    localparam int ITEM_W = $bits(item_t);

    // result word, active_mask in the lowest bits
    typedef struct packed {
        logic [PIN_W-1:0] press_mask;
        logic [PIN_W-1:0] active_mask;
    } result_t;

    // decoded command for one pin lane
    typedef struct packed {
        logic tick;
        logic edge_hit;
        logic ack_hit;
    } lane_cmd_t;

endpackage

/* design/multi_pin_debouncer.sv */
// ----------------------------------------------------------------------------
// multi_pin_debouncer - edge triggered timed debouncer for several pins
// Input register, per-pin debounce lanes and a result register.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one word per event - a tick carrying the raw level of
//   every pin, an edge seen on one pin, or an acknowledge of one pin's press.
//   Master channel m_*: exactly one word per input word, in order, holding
//   the debounced active mask and the sticky press mask after that event.
//   Config port cfg_*: write debounce_ticks (index 0) or active_high_mask
//   (index 1) while the block is idle; writes take effect at once.
// Timing:
//   A word is held in the input register, then in the result register,
//   where m_tvalid shows it. Throughput is one word per cycle while m_tready
//   is high: all pin lanes update in parallel in the single logic level
//   between the two registers.
// Reset:
//   aresetn low empties both registers and clears all timers and press flags;
//   stable levels read low, so active-low pins show active after reset.
//   Registers return to 10 ticks and all pins active high.
// Backpressure:
//   With m_tready low the result is held; one more word is still taken into
//   the input register, after which s_tready drops until the result leaves.
// ----------------------------------------------------------------------------
module multi_pin_debouncer
    import mpd_pkg::*;
#(
    parameter int NUM_PINS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    // s_tdata: action[1:0], pin_index[4:2], pin_levels[12:5], zero pad
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    // m_tdata: active_mask[7:0], press_mask[15:8]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    input  logic                cfg_we,
    input  logic [CFG_A_W-1:0]  cfg_addr,
    input  logic [TICKS_W-1:0]  cfg_wdata
);

    // only the low eight pins can be addressed or seen
    localparam int LANES = (NUM_PINS < PIN_W) ? NUM_PINS : PIN_W;

    logic               item_valid;
    item_t              item;
    logic               move;
    logic               out_valid_reg, out_valid_next;
    result_t            res_reg, res_next;
    logic [TICKS_W-1:0] ticks_reg;
    logic [PIN_W-1:0]   ahm_reg;
    logic [PIN_W-1:0]   active_vec;
    logic [PIN_W-1:0]   press_vec;

    // ---- configuration registers ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg <= DEBOUNCE_TICKS_RST;
            ahm_reg   <= ACTIVE_HIGH_MASK_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_DEBOUNCE_TICKS:   ticks_reg <= cfg_wdata;
                REG_ACTIVE_HIGH_MASK: ahm_reg   <= cfg_wdata[PIN_W-1:0];
                default: ;
            endcase
        end
    end

    // ---- input register ----
    mpd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (move),
        .item_valid (item_valid),
        .item       (item)
    );

    // advance a held word whenever the result register is free or draining
    assign move = item_valid && (!out_valid_reg || m_tready);

    // ---- per-pin lanes ----
    for (genvar i = 0; i < PIN_W; i++) begin : g_pin
        if (i < LANES) begin : g_lane
            lane_cmd_t cmd;
            logic      stable_nx;
            logic      pressed_nx;

            assign cmd.tick     = (item.action == ACT_TICK);
            assign cmd.edge_hit = (item.action == ACT_EDGE) &&
                                  (item.pin_index == IDX_W'(i));
            assign cmd.ack_hit  = (item.action == ACT_ACK) &&
                                  (item.pin_index == IDX_W'(i));

            mpd_pin_lane u_lane (
                .aclk           (aclk),
                .aresetn        (aresetn),
                .en             (move),
                .cmd            (cmd),
                .level          (item.pin_levels[i]),
                .active_high    (ahm_reg[i]),
                .debounce_ticks (ticks_reg),
                .stable_nx      (stable_nx),
                .pressed_nx     (pressed_nx)
            );

            assign active_vec[i] = ~(stable_nx ^ ahm_reg[i]);
            assign press_vec[i]  = pressed_nx;
        end else begin : g_none
            // pin without a lane: never active, never pressed
            assign active_vec[i] = 1'b0;
            assign press_vec[i]  = 1'b0;
        end
    end

    // ---- result register ----
    always_comb begin
        res_next             = res_reg;
        res_next.active_mask = active_vec;
        res_next.press_mask  = press_vec;
    end

    assign out_valid_next = move || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (move) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(res_reg);

`ifndef NO_ASSERTIONS
    // out of reset, both sides start empty
    a_reset_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> (s_tready && !m_tvalid))
        else $error("block not empty after reset");

    // a held word reaches a free result register in the next cycle
    a_word_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && !out_valid_reg) |=> out_valid_reg)
        else $error("held word did not advance");

    // an acknowledge clears that pin's press flag in its result
    a_ack_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (move && (item.action == ACT_ACK)) |=>
        !res_reg.press_mask[$past(item.pin_index)])
        else $error("acknowledged press still reported");

    // pins without a lane never show up in a result
    a_no_ghost_pins: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (((res_reg.press_mask | res_reg.active_mask) &
                       ~PIN_W'((64'd1 << LANES) - 64'd1)) == '0))
        else $error("result bit set for a pin without a lane");
`endif

endmodule

/* design/mpd_in_stage.sv */
// ----------------------------------------------------------------------------
// mpd_in_stage - input word register
// Captures an accepted word and holds it until the update stage takes it.
// ----------------------------------------------------------------------------
module mpd_in_stage
    import mpd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                take,
    output logic                item_valid,
    output item_t               item
);

    logic  valid_reg, valid_next;
    item_t item_reg;

    // accept when empty or when the held word leaves this cycle
    assign s_tready   = !valid_reg || take;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= item_t'(s_tdata[ITEM_W-1:0]);
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* design/mpd_pin_lane.sv */
// ----------------------------------------------------------------------------
// mpd_pin_lane - debounce timer and state of one pin
// Holds busy flag, wait count, stable level and sticky press flag; gives the
// values after the current command.
// ----------------------------------------------------------------------------
module mpd_pin_lane
    import mpd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  lane_cmd_t          cmd,
    input  logic               level,
    input  logic               active_high,
    input  logic [TICKS_W-1:0] debounce_ticks,
    output logic               stable_nx,
    output logic               pressed_nx
);

    logic               busy_reg, busy_next;
    logic [TICKS_W-1:0] count_reg, count_next;
    logic               stable_reg, stable_next;
    logic               pressed_reg, pressed_next;
    logic [TICKS_W-1:0] count_inc;
    logic               done;

    assign count_inc = count_reg + TICKS_W'(1);
    // zero time behaves as one tick; wrap of the count also ends the wait
    assign done      = (count_inc >= debounce_ticks) || (count_inc == '0);

    always_comb begin
        busy_next    = busy_reg;
        count_next   = count_reg;
        stable_next  = stable_reg;
        pressed_next = pressed_reg;
        if (cmd.tick && busy_reg) begin
            count_next = count_inc;
            if (done) begin
                if (stable_reg != level) begin
                    stable_next = level;
                    if (level == active_high) begin
                        pressed_next = 1'b1;
                    end
                end
                busy_next  = 1'b0;
                count_next = '0;
            end
        end
        // edge while busy is dropped, the timer keeps running
        if (cmd.edge_hit && !busy_reg) begin
            busy_next  = 1'b1;
            count_next = '0;
        end
        if (cmd.ack_hit) begin
            pressed_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            count_reg   <= '0;
            stable_reg  <= 1'b0;
            pressed_reg <= 1'b0;
        end else if (en) begin
            busy_reg    <= busy_next;
            count_reg   <= count_next;
            stable_reg  <= stable_next;
            pressed_reg <= pressed_next;
        end
    end

    assign stable_nx  = stable_next;
    assign pressed_nx = pressed_next;

endmodule

/* verif/tb_multi_pin_debouncer.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_pin_debouncer - self-checking bench for the multi-pin debouncer
// Drives tick, edge and acknowledge words into the slave stream and checks
// every master word against an in-bench model of the per-pin timers, stable
// levels and sticky press flags. A short directed table opens the run. Random
// phases follow, each under its own debounce time and polarity; all but the
// last have random backpressure and source gaps.
// ----------------------------------------------------------------------------
module tb_multi_pin_debouncer;
    import mpd_pkg::*;

    localparam int NUM_PINS       = 8;
    localparam int WATCHDOG_LIMIT = 4000;  // quiet cycles before giving up
    localparam int DRAIN_CYCLES   = 8;     // settle time after the last result
    localparam int MAX_REPORTS    = 10;

    // action code the block must ignore
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

    // one step of the directed table: a stream word or a register write
    typedef struct {
        row_kind_t           kind;
        logic [CFG_A_W-1:0]  reg_idx;
        logic [TICKS_W-1:0]  reg_val;
        item_t               word;     // {pin_levels, pin_index, action}
        logic                typed;    // 1: want_res below is the expected word
        result_t             want_res; // {press_mask, active_mask}
    } dir_row_t;

    localparam int N_ROWS = 26;

    // Opening rows check the reset state by hand; the rest go to the model.
    dir_row_t directed_rows [N_ROWS] = '{
        '{ROW_WORD, REG_DEBOUNCE_TICKS, 10'd0, {8'h00, 3'd0, ACT_TICK},   1'b1, {8'h00, 8'h00}},
        '{ROW_WORD, REG_DEBOUNCE_TICKS, 10'd0, {8'h00, 3'd2, ACT_EDGE},   1'b1, {8'h00, 8'h00}},
        '{ROW_WORD, REG_DEBOUNCE_TICKS, 10'd0, {8'hFF, 3'd7, ACT_UNUSED}, 1'b1, {8'h00, 8'h00}},
        '{ROW_WORD, REG_DEBOUNCE_TICKS, 10'd0, {8'h00, 3'd7, ACT_ACK},    1'b1, {8'h00, 8'h00}},
        // zero debounce time: sample on the very next tick
        '{ROW_REG,  REG_DEBOUNCE_TICKS, 10'd0, '0,                         1'b0, '0},
        '{ROW_WORD, REG_DEBOUNCE_TICKS, 10'd0, {8'hFF, 3'd0, ACT_TICK},   1'b0, '0},
        // flip every pin to active low: mask moves at once, no new press
        '{ROW_REG,  REG_ACTIVE_HIGH_MASK, 10'h000, '0,                     1'b0, '0},
        '{ROW_WORD, REG_DEBOUNCE_TICKS, 10'd0, {8'h00, 3'd0, ACT_TICK},   1'b0, '0},
        '{ROW_WORD, REG_DEBOUNCE_TICKS, 10'd0, {8'h00, 3'd0, ACT_EDGE},   1'b0, '0},
        '{ROW_WORD, REG_DEBOUNCE_TICKS, 10'd0, {8'h00, 3'd7, ACT_EDGE},   1'b0, '0},
        // edge while busy: timer keeps running
        '{ROW_WORD, REG_DEBOUNCE_TICKS, 10'd0, {8'h00, 3'd0, ACT_EDGE},   1'b0, '0},
        '{ROW_WORD, REG_DEBOUNCE_TICKS, 10'd0, {8'h7F, 3'd0, ACT_TICK},   1'b0, '0},
        '{ROW_WORD, REG_DEBOUNCE_TICKS, 10'd0, {8'h00, 3'd2, ACT_ACK},    1'b0, '0},
        '{ROW_REG,  REG_DEBOUNCE_TICKS, 10'd2, '0,                         1'b0, '0},
        '{ROW_REG,  REG_ACTIVE_HIGH_MASK, 10'h0FF, '0,                     1'b0, '0},
        '{ROW_WORD, REG_DEBOUNCE_TICKS, 10'd0, {8'h00, 3'd7, ACT_EDGE},   1'b0, '0},
        '{ROW_WORD, REG_DEBOUNCE_TICKS, 10'd0, {8'h80, 3'd0, ACT_TICK},   1'b0, '0},
        '{ROW_WORD, REG_DEBOUNCE_TICKS, 10'd0, {8'h00, 3'd7, ACT_EDGE},   1'b0, '0},
        '{ROW_WORD, REG_DEBOUNCE_TICKS, 10'd0, {8'h00, 3'd0, ACT_TICK},   1'b0, '0},
        '{ROW_WORD, REG_DEBOUNCE_TICKS, 10'd0, {8'h00, 3'd5, ACT_EDGE},   1'b0, '0},
        '{ROW_WORD, REG_DEBOUNCE_TICKS, 10'd0, {8'hFF, 3'd0, ACT_TICK},   1'b0, '0},
        '{ROW_WORD, REG_DEBOUNCE_TICKS, 10'd0, {8'hFF, 3'd0, ACT_TICK},   1'b0, '0},
        // longest debounce time: the timer stays busy
        '{ROW_REG,  REG_DEBOUNCE_TICKS, 10'd1023, '0,                      1'b0, '0},
        '{ROW_WORD, REG_DEBOUNCE_TICKS, 10'd0, {8'h00, 3'd1, ACT_EDGE},   1'b0, '0},
        '{ROW_WORD, REG_DEBOUNCE_TICKS, 10'd0, {8'hFF, 3'd0, ACT_TICK},   1'b0, '0},
        '{ROW_WORD, REG_DEBOUNCE_TICKS, 10'd0, {8'h00, 3'd5, ACT_ACK},    1'b0, '0}
    };

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_we    = 1'b0;
    logic [CFG_A_W-1:0]  cfg_addr  = '0;
    logic [TICKS_W-1:0]  cfg_wdata = '0;

    // Travels beside s_tdata so the checker sees it at the same edge.
    logic    row_typed  = 1'b0;
    result_t row_result = '0;

    // idle percentages of the source and the sink
    int snd_idle_pct = 14;
    int rcv_idle_pct = 57;

    // model state: configuration and per-pin debounce state
    logic [TICKS_W-1:0] hold_ticks;
    logic [PIN_W-1:0]   polarity;
    logic [PIN_W-1:0]   settled_levels;
    logic [PIN_W-1:0]   timing_pins;
    logic [PIN_W-1:0]   latched_presses;
    logic [TICKS_W-1:0] elapsed_ticks [PIN_W];

    result_t expected_masks [$];
    result_t want;
    result_t got;
    int      in_flight      = 0;
    int      mismatch_count = 0;
    int      results_seen   = 0;
    int      quiet_cycles   = 0;

    multi_pin_debouncer #(
        .NUM_PINS(NUM_PINS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Advance the model by one accepted word and return the masks after it.
    task automatic debounce_event(input item_t w, output result_t r);
        case (w.action)
            ACT_TICK: begin
                for (int p = 0; p < NUM_PINS; p++) begin
                    if (timing_pins[p]) begin
                        elapsed_ticks[p] = elapsed_ticks[p] + 1'b1;
                        // a zero debounce time acts as one tick
                        if (elapsed_ticks[p] >= hold_ticks || elapsed_ticks[p] == '0) begin
                            if (settled_levels[p] != w.pin_levels[p]) begin
                                settled_levels[p] = w.pin_levels[p];
                                if (w.pin_levels[p] == polarity[p])
                                    latched_presses[p] = 1'b1;
                            end
                            timing_pins[p]   = 1'b0;
                            elapsed_ticks[p] = '0;
                        end
                    end
                end
            end
            ACT_EDGE: begin
                // drop edges on a pin that is already timing
                if (int'(w.pin_index) < NUM_PINS && !timing_pins[w.pin_index]) begin
                    timing_pins[w.pin_index]   = 1'b1;
                    elapsed_ticks[w.pin_index] = '0;
                end
            end
            ACT_ACK: begin
                if (int'(w.pin_index) < NUM_PINS)
                    latched_presses[w.pin_index] = 1'b0;
            end
            default: ;
        endcase
        r.active_mask = ~(settled_levels ^ polarity);
        r.press_mask  = latched_presses;
    endtask

    // Checker: track register writes, compare each result word with the
    // oldest expectation, then queue the expectation for each new word.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_ticks      = DEBOUNCE_TICKS_RST;
            polarity        = ACTIVE_HIGH_MASK_RST;
            settled_levels  = '0;
            timing_pins     = '0;
            latched_presses = '0;
            for (int p = 0; p < PIN_W; p++)
                elapsed_ticks[p] = '0;
            expected_masks.delete();
            in_flight <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_DEBOUNCE_TICKS:   hold_ticks = cfg_wdata;
                    REG_ACTIVE_HIGH_MASK: polarity   = cfg_wdata[PIN_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(result_t)-1:0];
                if (expected_masks.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: result word %h with nothing expected", $realtime, got);
                end else begin
                    want = expected_masks.pop_front();
                    if (got.active_mask !== want.active_mask
                            || got.press_mask !== want.press_mask) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("%0t: word %0d active_mask exp %h got %h, press_mask exp %h got %h",
                                     $realtime, results_seen, want.active_mask, got.active_mask,
                                     want.press_mask, got.press_mask);
                    end
                end
                results_seen++;
            end
            if (s_tvalid && s_tready) begin
                debounce_event(s_tdata[ITEM_W-1:0], want);
                // hand-typed rows override the model's answer
                expected_masks.push_back(row_typed ? row_result : want);
            end
            in_flight <= in_flight + int'(s_tvalid && s_tready) - int'(m_tvalid && m_tready);
        end
    end

    // Sink: stall at random according to the current idle percentage.
    always @(posedge aclk)
        m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);

    // Watchdog: give up after a long stretch with no transfer of any kind.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Hold until every accepted word has produced its result.
    task automatic wait_drained();
        do
            @(posedge aclk);
        while (in_flight != 0);
    endtask

    // Offer one word, optionally after a short gap, and hold it until taken.
    task automatic push_word(input item_t w, input logic typed, input result_t typed_res);
        if ($urandom_range(0, 99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= {{(S_DATA_W-ITEM_W){1'b0}}, w};
        row_typed  <= typed;
        row_result <= typed_res;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // Write one register once the block has gone idle.
    task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [TICKS_W-1:0] val);
        s_tvalid <= 1'b0;
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Mostly ticks and edges so timers start and expire; some acks and noise.
    function automatic item_t random_word();
        item_t w;
        int    r;
        r            = $urandom_range(0, 99);
        w.pin_levels = PIN_W'($urandom_range(0, 255));
        w.pin_index  = IDX_W'($urandom_range(0, 7));
        if (r < 55)
            w.action = ACT_TICK;
        else if (r < 80)
            w.action = ACT_EDGE;
        else if (r < 95)
            w.action = ACT_ACK;
        else
            w.action = ACT_UNUSED;
        return w;
    endfunction

    // Set the registers, then stream random words; pause once midway until
    // the pipeline is empty.
    task automatic run_phase(input int n_words, input logic [TICKS_W-1:0] ticks,
                             input logic [PIN_W-1:0] pol);
        write_reg(REG_DEBOUNCE_TICKS, ticks);
        write_reg(REG_ACTIVE_HIGH_MASK, {{(TICKS_W-PIN_W){1'b0}}, pol});
        for (int i = 0; i < n_words; i++) begin
            if (i == n_words / 2) begin
                s_tvalid <= 1'b0;
                wait_drained();
            end
            push_word(random_word(), 1'b0, '0);
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table, source idles more rarely than the sink
        for (int i = 0; i < N_ROWS; i++) begin
            if (directed_rows[i].kind == ROW_REG)
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            else
                push_word(directed_rows[i].word, directed_rows[i].typed,
                          directed_rows[i].want_res);
        end

        run_phase(300, 10'd3, 8'hA5);
        run_phase(250, 10'd0, 8'h00);

        // swap the idle rates: source idles more than the sink
        snd_idle_pct = 57;
        rcv_idle_pct = 14;
        run_phase(120, 10'd1023, 8'hFF);
        run_phase(250, 10'd1, 8'($urandom_range(0, 255)));

        // full rate on both sides
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        run_phase(330, 10'd12, 8'($urandom_range(0, 255)));

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
